### rtl/bvhm_pkg.sv
package bvhm_pkg;

	localparam int WORD_BITS = 64;
	localparam int MAX_SITES = 65536;
	localparam int SITE_W    = $clog2(WORD_BITS + 1);
	localparam int IDX_W     = $clog2(WORD_BITS);
	localparam int CNT_W     = $clog2(MAX_SITES + 1);
	localparam int OUT_W     = 17;
	localparam int IN_DATA_W  = ((2 * WORD_BITS + SITE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

	// per-word summary of the masked difference vector
	typedef struct packed {
		logic [SITE_W-1:0] pop;    // differing sites
		logic [SITE_W-1:0] pre;    // equal sites before the first difference
		logic [SITE_W-1:0] suf;    // equal sites after the last difference
		logic [SITE_W-1:0] mid;    // longest run of equal sites in the word
		logic [SITE_W-1:0] n;      // valid sites, clipped to the word width
		logic              zero;   // no difference in the valid sites
		logic              last;
	} word_sum_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
	                                             input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > (CNT_W+1)'(MAX_SITES))
			return CNT_W'(MAX_SITES);
		return s[CNT_W-1:0];
	endfunction

endpackage

### rtl/bit_vector_hamming_and_match_run.sv
// Compares two bit vectors streamed as pairs of 64-bit words (site 0 at bit 0) and,
// on the transfer marked tlast, returns the Hamming distance over the valid sites and
// the longest run of equal sites, a run carrying across word boundaries. Sites above
// sites_in_word are ignored; a count above 64 counts as 64. Both totals saturate at
// MAX_SITES and all state clears after the last word. One word pair is taken every
// clock cycle while no held result blocks it: the word summary (popcount, edge runs,
// longest inner run) is one stage of parallel bit logic, the running totals update in
// the next, and the result is registered as the last word leaves that stage. A held
// result does not stop the flow until the two internal stages are full.
module bit_vector_hamming_and_match_run (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// word_a, word_b, sites_in_word, zero pad
	input  logic [bvhm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// last_word
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// hamming_distance, longest_match_run, zero pad
	output logic [bvhm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import bvhm_pkg::*;

	logic                  v_s1;
	logic [WORD_BITS-1:0]  a_s1;
	logic [WORD_BITS-1:0]  b_s1;
	logic [SITE_W-1:0]     sites_s1;
	logic                  last_s1;

	logic                  v_s2;
	word_sum_t             sum_s2;
	word_sum_t             sum_c;

	logic [CNT_W-1:0]      dist_q;
	logic [CNT_W-1:0]      cur_q;
	logic [CNT_W-1:0]      best_q;
	logic [CNT_W-1:0]      dist_n;
	logic [CNT_W-1:0]      cur_n;
	logic [CNT_W-1:0]      best_n;
	logic [CNT_W-1:0]      head_run;
	logic [CNT_W-1:0]      final_run;

	logic                  out_v_q;
	logic [OUT_W-1:0]      hd_q;
	logic [OUT_W-1:0]      lr_q;

	logic                  adv1;
	logic                  adv2;
	logic                  s1_free;
	logic                  s2_free;

	logic [WORD_BITS-1:0]  mask;
	logic [WORD_BITS-1:0]  diff;
	logic [WORD_BITS-1:0]  eq;
	logic [WORD_BITS-1:0]  win [1:WORD_BITS];
	logic [WORD_BITS-1:0]  has_run;
	logic [IDX_W-1:0]      hi_idx;

	// flow control: each stage moves when the next one is empty or moving
	assign adv2    = v_s2 & (~sum_s2.last | ~out_v_q | m_axis_tready);
	assign s2_free = ~v_s2 | adv2;
	assign adv1    = v_s1 & s2_free;
	assign s1_free = ~v_s1 | adv1;
	assign s_axis_tready = s1_free;

	// word summary
	always_comb begin
		sum_c.n    = (sites_s1 > SITE_W'(WORD_BITS)) ? SITE_W'(WORD_BITS) : sites_s1;
		sum_c.last = last_s1;
		for (int i = 0; i < WORD_BITS; i++)
			mask[i] = (SITE_W'(i) < sum_c.n);
		diff = (a_s1 ^ b_s1) & mask;
		eq   = ~(a_s1 ^ b_s1) & mask;
		sum_c.zero = (diff == '0);

		sum_c.pop = '0;
		for (int i = 0; i < WORD_BITS; i++)
			sum_c.pop = sum_c.pop + SITE_W'(diff[i]);

		sum_c.pre = sum_c.n;
		for (int i = WORD_BITS - 1; i >= 0; i--)
			if (diff[i])
				sum_c.pre = SITE_W'(i);

		hi_idx = '0;
		for (int i = 0; i < WORD_BITS; i++)
			if (diff[i])
				hi_idx = IDX_W'(i);
		sum_c.suf = sum_c.n - SITE_W'(hi_idx) - SITE_W'(1);

		// win[l][i]: sites i .. i+l-1 are all valid and equal; built by halving l
		win[1] = eq;
		for (int l = 2; l <= WORD_BITS; l++)
			win[l] = win[l >> 1] & (win[l - (l >> 1)] >> (l >> 1));
		for (int l = 1; l <= WORD_BITS; l++)
			has_run[l-1] = |win[l];
		// has_run is a thermometer code, so its weight is the longest run
		sum_c.mid = '0;
		for (int i = 0; i < WORD_BITS; i++)
			sum_c.mid = sum_c.mid + SITE_W'(has_run[i]);
	end

	// running totals
	always_comb begin
		dist_n   = sat_add(dist_q, CNT_W'(sum_s2.pop));
		head_run = sat_add(cur_q, CNT_W'(sum_s2.pre));
		if (sum_s2.zero) begin
			cur_n  = sat_add(cur_q, CNT_W'(sum_s2.n));
			best_n = best_q;
		end else begin
			cur_n  = CNT_W'(sum_s2.suf);
			best_n = best_q;
			if (head_run > best_n)
				best_n = head_run;
			if (CNT_W'(sum_s2.mid) > best_n)
				best_n = CNT_W'(sum_s2.mid);
		end
		final_run = (cur_n > best_n) ? cur_n : best_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			dist_q  <= '0;
			cur_q   <= '0;
			best_q  <= '0;
		end else begin
			if (s1_free)
				v_s1 <= s_axis_tvalid;
			if (s2_free)
				v_s2 <= v_s1;
			if (adv2 && sum_s2.last)
				out_v_q <= 1'b1;
			else if (m_axis_tready)
				out_v_q <= 1'b0;
			if (adv2) begin
				if (sum_s2.last) begin
					dist_q  <= '0;
					cur_q   <= '0;
					best_q  <= '0;
				end else begin
					dist_q  <= dist_n;
					cur_q   <= cur_n;
					best_q  <= best_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && s_axis_tvalid) begin
			a_s1     <= s_axis_tdata[WORD_BITS-1:0];
			b_s1     <= s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
			sites_s1 <= s_axis_tdata[2*WORD_BITS+SITE_W-1:2*WORD_BITS];
			last_s1  <= s_axis_tlast;
		end
		if (adv1)
			sum_s2 <= sum_c;
		if (adv2 && sum_s2.last) begin
			hd_q <= OUT_W'(dist_n);
			lr_q <= OUT_W'(final_run);
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {(OUT_DATA_W - 2 * OUT_W)'(0), lr_q, hd_q};

	a_state_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dist_q <= CNT_W'(MAX_SITES) && cur_q <= CNT_W'(MAX_SITES) &&
		best_q <= CNT_W'(MAX_SITES))
		else $error("running count above saturation limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && sum_s2.last |=> dist_q == '0 && cur_q == '0 && best_q == '0)
		else $error("state not cleared after last word");

	a_result_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 && sum_s2.last |=> m_axis_tvalid)
		else $error("last word gave no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !(adv2 && sum_s2.last))
		else $error("held result overwritten");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1 && v_s2)
		else $error("input stalled with a free stage");

endmodule

### tb/tb_bit_vector_hamming_and_match_run.sv
module tb_bit_vector_hamming_and_match_run;
	timeunit 1ns;
	timeprecision 1ps;

	import bvhm_pkg::IN_DATA_W;
	import bvhm_pkg::OUT_DATA_W;
	import bvhm_pkg::WORD_BITS;
	import bvhm_pkg::MAX_SITES;

	typedef struct {
		logic [63:0] word_a;
		logic [63:0] word_b;
		logic [6:0]  sites;
		logic        last;
	} word_pair_t;

	typedef struct {
		logic [16:0] hamming;
		logic [16:0] run;
	} totals_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	word_pair_t word_feed[$];
	totals_t    totals_due[$];
	word_pair_t on_bus;
	logic       word_taken = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_ask = 1'b0;
	bit hold_ack = 1'b0;
	int hold_left = 0;

	// running state of the comparison, mirrors the block
	int dist_sum = 0;
	int cur_run = 0;
	int best_run = 0;

	int words_sent = 0;
	int vectors_sent = 0;
	int totals_seen = 0;
	int mismatches = 0;

	bit_vector_hamming_and_match_run dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic int clip_sites(input int v);
		return (v > MAX_SITES) ? MAX_SITES : v;
	endfunction

	// fold one word pair into the totals; returns 1 when a result is due
	function automatic bit fold_word(input word_pair_t w, output totals_t t);
		int n;
		logic [63:0] mask;
		logic [63:0] diff;
		n = (w.sites > WORD_BITS) ? WORD_BITS : int'(w.sites);
		mask = (n == WORD_BITS) ? '1 : ((64'd1 << n) - 64'd1);
		diff = (w.word_a ^ w.word_b) & mask;
		dist_sum = clip_sites(dist_sum + $countones(diff));
		for (int i = 0; i < n; i++) begin
			if (diff[i]) begin
				if (cur_run > best_run)
					best_run = cur_run;
				cur_run = 0;
			end else begin
				cur_run = clip_sites(cur_run + 1);
			end
		end
		t.hamming = '0;
		t.run = '0;
		if (!w.last)
			return 1'b0;
		if (cur_run > best_run)
			best_run = cur_run;
		t.hamming = dist_sum[16:0];
		t.run = best_run[16:0];
		dist_sum = 0;
		cur_run = 0;
		best_run = 0;
		return 1'b1;
	endfunction

	task automatic add_word(input logic [63:0] a, input logic [63:0] b,
	                        input logic [6:0] sites, input bit last);
		word_pair_t w;
		w.word_a = a;
		w.word_b = b;
		w.sites = sites;
		w.last = last;
		word_feed.push_back(w);
		words_sent++;
		if (last)
			vectors_sent++;
	endtask

	// content varies in difference density so runs of all lengths show up
	task automatic add_random_vector(input int nwords);
		logic [63:0] a;
		logic [63:0] d;
		logic [6:0] sites;
		for (int k = 0; k < nwords; k++) begin
			a = {$urandom, $urandom};
			case ($urandom_range(5))
				0: d = '0;
				1: d = '1;
				2: d = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				3: d = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
				4: d = {$urandom, $urandom};
				default: d = 64'd1 << $urandom_range(63);
			endcase
			if ($urandom_range(9) == 0)
				sites = 7'($urandom_range(127));
			else if (k == nwords - 1 || $urandom_range(4) == 0)
				sites = 7'($urandom_range(64, 1));
			else
				sites = 7'd64;
			add_word(a, a ^ d, sites, k == nwords - 1);
		end
	endtask

	task automatic add_random_vectors(input int n_words);
		int goal;
		goal = words_sent + n_words;
		while (words_sent < goal) begin
			if ($urandom_range(19) == 0)
				add_random_vector($urandom_range(40, 9));
			else
				add_random_vector($urandom_range(8, 1));
		end
	endtask

	task automatic drain();
		while (word_feed.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		for (int c = 0; c < 5000 && totals_due.size() != 0; c++)
			@(posedge clk);
	endtask

	// sender: new word offered at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || word_taken) begin
			if (word_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				on_bus = word_feed.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {{(IN_DATA_W - 135){1'b0}}, on_bus.sites,
				                 on_bus.word_b, on_bus.word_a};
				s_axis_tlast <= on_bus.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with an occasional long hold-off on request
	always @(negedge clk) begin
		if (hold_ask != hold_ack) begin
			hold_ack <= hold_ask;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		totals_t t;
		totals_t want;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			if (fold_word(on_bus, t))
				totals_due.push_back(t);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			totals_seen++;
			if (totals_due.size() == 0) begin
				$error("result transfer with no result expected: tdata=%h", m_axis_tdata);
				mismatches++;
			end else begin
				want = totals_due.pop_front();
				if (m_axis_tdata[16:0] !== want.hamming) begin
					$error("hamming_distance: expected %0d, got %0d",
					       want.hamming, m_axis_tdata[16:0]);
					mismatches++;
				end
				if (m_axis_tdata[33:17] !== want.run) begin
					$error("longest_match_run: expected %0d, got %0d",
					       want.run, m_axis_tdata[33:17]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 17;
		recv_idle_pct = 86;
		add_word('0, '0, 7'd64, 1'b1);
		add_word('1, '0, 7'd64, 1'b1);
		add_word('1, '0, 7'd0, 1'b1);             // zero sites, still emits
		add_word(64'h1, '0, 7'd127, 1'b1);        // count above word width
		add_word(64'h8000_0000_0000_0001, '0, 7'd65, 1'b1);
		add_word(64'hFFFF_FFFF_FFFF_FFFE, '0, 7'd1, 1'b1);  // high bits masked
		// run spans the word boundary
		add_word(64'h1, '0, 7'd64, 1'b0);
		add_word(64'h8000_0000_0000_0000, '0, 7'd64, 1'b1);
		add_word('1, '0, 7'd0, 1'b0);
		add_word('0, 64'h10, 7'd5, 1'b1);
		add_word(64'h5555_5555_5555_5555, '0, 7'd64, 1'b1);
		add_word(64'hAAAA_AAAA_AAAA_AAAA, '1, 7'd64, 1'b1);
		add_word(64'h8000_0000_0000_0000, '0, 7'd64, 1'b0);
		add_word('1, '0, 7'd64, 1'b0);
		add_word('0, '0, 7'd33, 1'b0);
		add_word('0, '1, 7'd64, 1'b1);
		add_word('0, '0, 7'd64, 1'b0);
		add_word('0, '0, 7'd64, 1'b0);
		add_word(64'h0000_0001_0000_0000, '0, 7'd64, 1'b1);
		add_random_vectors(400);
		drain();

		send_idle_pct = 86;
		recv_idle_pct = 17;
		add_random_vectors(400);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// long receiver stall while single-word vectors keep arriving
		hold_ask = ~hold_ask;
		for (int k = 0; k < 40; k++)
			add_random_vector(1);
		drain();
		// longest run past the saturation point
		for (int k = 0; k < 1024; k++)
			add_word('0, '0, 7'd64, 1'b0);
		add_word(64'h5, 64'h5, 7'd64, 1'b1);
		add_random_vectors(150);
		drain();
		repeat (20) @(posedge clk);

		if (totals_due.size() != 0) begin
			$error("%0d results never arrived", totals_due.size());
			mismatches++;
		end
		$display("Covered %0d word pairs in %0d vector pairs, %0d totals compared,",
		         words_sent, vectors_sent, totals_seen);
		$display("including masked and out-of-range site counts and a saturated run length.");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### bit_vector_hamming_and_match_run.f
rtl/bvhm_pkg.sv
rtl/bit_vector_hamming_and_match_run.sv
tb/tb_bit_vector_hamming_and_match_run.sv
